>>> hw/rtl/oaids_pkg.sv
// Shared types, codes and sizes for the ordered list block.
package oaids_pkg;

   // Default capacity and field widths
   localparam int DEPTH_DEF = 64;
   localparam int WORD_W    = 32;
   localparam int MODE_W    = 3;
   localparam int INDEX_W   = 6;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   // Request operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT_AT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT_FIRST = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT_LAST  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE_AT    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DELETE_FIRST = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DELETE_LAST  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_GET          = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SEARCH       = 3'd7;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD       = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // What every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_GET,
      CELL_SEARCH
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [WORD_W-1:0]   value;
   } cell_cmd_type;

   // Candidate carried up the selection tree
   typedef struct packed {
      logic                hit;
      logic [WORD_W-1:0]   word;
   } leaf_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

endpackage

>>> hw/rtl/oaids_cell.sv
// One list cell: holds an entry, shifts with its neighbours, offers a tree leaf.
module oaids_cell #(
   parameter int IDX   = 0,
   parameter int POS_W = 7
) (
   input  logic                           clock,
   input  oaids_pkg::cell_cmd_type        cmd,
   input  logic [POS_W-1:0]               pos,
   input  logic [POS_W-1:0]               count,
   input  logic [oaids_pkg::WORD_W-1:0]   below,
   input  logic [oaids_pkg::WORD_W-1:0]   above,
   output logic [oaids_pkg::WORD_W-1:0]   entry,
   output oaids_pkg::leaf_type            leaf
);
   import oaids_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   logic [WORD_W-1:0] entry_ff;
   logic [WORD_W-1:0] entry_in;

   // Shift or write the entry
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MY_POS > pos) begin
               entry_in = below;
            end else if (MY_POS == pos) begin
               entry_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            if (MY_POS >= pos) begin
               entry_in = above;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Leaf: entry for a read, own position for a search match
   always_comb begin
      leaf = '0;
      case (cmd.op)
         CELL_GET: begin
            leaf.hit  = (MY_POS == pos);
            leaf.word = entry_ff;
         end
         CELL_SEARCH: begin
            leaf.hit  = (MY_POS < count) && (entry_ff == cmd.value);
            leaf.word = WORD_W'(IDX);
         end
         default: begin
            leaf = '0;
         end
      endcase
   end

   assign entry = entry_ff;

endmodule

>>> hw/rtl/oaids_node.sv
// Registered selection node: keeps the lower-position hit of two candidates.
module oaids_node (
   input  logic                  clock,
   input  oaids_pkg::leaf_type   lo,
   input  oaids_pkg::leaf_type   hi,
   output oaids_pkg::leaf_type   res
);
   import oaids_pkg::*;

   leaf_type res_ff;
   leaf_type res_in;

   // Lower position wins, so a search reports the first match
   always_comb begin
      res_in = lo.hit ? lo : hi;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

>>> hw/rtl/ordered_array_insert_delete_search.sv
// Top level of the ordered list: cell row, selection tree and request control.
//
// Keeps an ordered list of up to DEPTH signed 32-bit words in a row of cells.
// Requests arrive on the req_ channel (mode, index, value); each gives one
// word on the rsp_ channel (status, data, found_index, count). A word moves
// when valid is high and stall is low.
// Inserts and deletes shift all cells at and above the given position at once:
// the response is registered at the edge that takes the request. Reads and
// searches let every cell offer a candidate to a registered binary tree of
// clog2(DEPTH) levels; the response is registered from the tree root once the
// result has reached it, and the block takes no new request until then.
// One request is in flight at a time. A new request is taken while the last
// response is being taken, or once it has gone; req_stall is high while a
// read or search is in the tree and while a response waits under rsp_stall.
// A stalled response holds its fields unchanged.
// Reset clears the entry count, the response valid and the control state; cell
// contents are left as they are and are never read before being written.
module ordered_array_insert_delete_search #(
   parameter int DEPTH = oaids_pkg::DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [oaids_pkg::MODE_W-1:0]           req_mode,
   input  logic [oaids_pkg::INDEX_W-1:0]          req_index,
   input  logic signed [oaids_pkg::WORD_W-1:0]    req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [oaids_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [oaids_pkg::WORD_W-1:0]    rsp_data,
   output logic [oaids_pkg::INDEX_W-1:0]          rsp_found_index,
   output logic [oaids_pkg::COUNT_W-1:0]          rsp_count
);
   import oaids_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LVL   = $clog2(DEPTH);
   localparam int NPOW  = 1 << LVL;
   localparam int POS_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int TMR_W = $clog2(LVL + 1);

   // Control state
   state_type           state_ff, state_in;
   logic [TMR_W-1:0]    tmr_ff, tmr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pend_get_ff, pend_get_in;
   logic                pend_bad_ff, pend_bad_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Response fields
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [INDEX_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                accept;
   logic                take;
   logic                load_rsp;
   logic                full;
   logic [POS_W-1:0]    pos_idx;
   logic [POS_W-1:0]    cnt_ext;
   logic [POS_W-1:0]    ins_pos;
   logic [POS_W-1:0]    del_pos;
   logic [POS_W-1:0]    cell_pos;
   cell_cmd_type        cmd;

   logic [WORD_W-1:0]   entry [DEPTH];
   leaf_type            node_q [2*NPOW-1];

   // Request decode, state and response control
   always_comb begin
      req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      take      = rsp_valid_ff && !rsp_stall;

      pos_idx = POS_W'(req_index);
      cnt_ext = POS_W'(count_ff);
      full    = (count_ff == CNT_W'(DEPTH));
      ins_pos = (req_mode == MODE_INSERT_FIRST) ? '0 :
                (req_mode == MODE_INSERT_LAST)  ? cnt_ext : pos_idx;
      del_pos = (req_mode == MODE_DELETE_FIRST) ? '0 :
                (req_mode == MODE_DELETE_LAST)  ? (cnt_ext - POS_W'(1)) : pos_idx;

      state_in     = state_ff;
      tmr_in       = tmr_ff;
      count_in     = count_ff;
      pend_get_in  = pend_get_ff;
      pend_bad_in  = pend_bad_ff;
      rsp_valid_in = rsp_valid_ff && !take;
      load_rsp     = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;

      cmd.op    = CELL_HOLD;
      cmd.value = req_value;
      cell_pos  = pos_idx;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_INSERT_AT, MODE_INSERT_FIRST, MODE_INSERT_LAST: begin
                     load_rsp     = 1'b1;
                     rsp_data_in  = '0;
                     rsp_found_in = '0;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (ins_pos > cnt_ext) begin
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        cmd.op        = CELL_INSERT;
                        cell_pos      = ins_pos;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_DELETE_AT, MODE_DELETE_FIRST, MODE_DELETE_LAST: begin
                     load_rsp     = 1'b1;
                     rsp_data_in  = '0;
                     rsp_found_in = '0;
                     if ((count_ff == '0) || (del_pos >= cnt_ext)) begin
                        rsp_status_in = STATUS_BAD;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        cmd.op        = CELL_DELETE;
                        cell_pos      = del_pos;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_GET, MODE_SEARCH: begin
                     cmd.op      = (req_mode == MODE_GET) ? CELL_GET : CELL_SEARCH;
                     pend_get_in = (req_mode == MODE_GET);
                     pend_bad_in = (pos_idx >= cnt_ext);
                     tmr_in      = TMR_W'(LVL - 1);
                     state_in    = ST_BUSY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BUSY: begin
            if (tmr_ff == '0) begin
               // Tree root now holds the result of the request
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               rsp_data_in  = '0;
               rsp_found_in = '0;
               if (pend_get_ff) begin
                  if (pend_bad_ff) begin
                     rsp_status_in = STATUS_BAD;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     rsp_data_in   = node_q[0].word;
                  end
               end else if (node_q[0].hit) begin
                  rsp_status_in = STATUS_OK;
                  rsp_found_in  = INDEX_W'(node_q[0].word);
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end else begin
               tmr_in = tmr_ff - TMR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(count_in);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tmr_ff       <= '0;
         count_ff     <= '0;
         pend_get_ff  <= 1'b0;
         pend_bad_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tmr_ff       <= tmr_in;
         count_ff     <= count_in;
         pend_get_ff  <= pend_get_in;
         pend_bad_ff  <= pend_bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response word
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Row of cells, each linked to its neighbours
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [WORD_W-1:0] below;
      logic [WORD_W-1:0] above;
      leaf_type          leaf;

      assign below = (k == 0) ? entry[k] : entry[(k == 0) ? 0 : k-1];
      assign above = (k == DEPTH-1) ? entry[k] : entry[(k == DEPTH-1) ? k : k+1];

      oaids_cell #(
         .IDX   (k),
         .POS_W (POS_W)
      ) u_cell (
         .clock (clock),
         .cmd   (cmd),
         .pos   (cell_pos),
         .count (cnt_ext),
         .below (below),
         .above (above),
         .entry (entry[k]),
         .leaf  (leaf)
      );

      assign node_q[NPOW-1+k] = leaf;
   end

   // Unused leaves of the padded tree
   for (genvar k = DEPTH; k < NPOW; k++) begin : g_pad
      assign node_q[NPOW-1+k] = '0;
   end

   // Registered selection tree, root at node 0
   for (genvar i = 0; i < NPOW-1; i++) begin : g_node
      oaids_node u_node (
         .clock (clock),
         .lo    (node_q[2*i+1]),
         .hi    (node_q[2*i+2]),
         .res   (node_q[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data        = rsp_data_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

endmodule
